### hw/rtl/register_use_def_checker_macros.svh
// Assertion macros for the register use/def checker.
`ifndef REGISTER_USE_DEF_CHECKER_MACROS_SVH
`define REGISTER_USE_DEF_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RUD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rud: assertion failed");

// Next-cycle implication, disabled during reset.
`define RUD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rud: assertion failed");

`endif

### hw/rtl/rud_pkg.sv
// Shared types and constants for the register use/def checker.
package rud_pkg;

  localparam int NUM_GP_REGS_DEF = 10;
  localparam int REG_IDX_W       = 4;
  localparam int PC_W            = 16;
  localparam int CNT_W           = 16;

  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_WRITTEN = 2'd1,
    ST_READ    = 2'd2
  } reg_status_t;

  typedef struct packed {
    logic                 program_start;
    logic [PC_W-1:0]      pc;
    logic                 is_label;
    logic                 src1_used;
    logic [REG_IDX_W-1:0] src1_reg;
    logic                 src2_used;
    logic [REG_IDX_W-1:0] src2_reg;
    logic                 dst_used;
    logic [REG_IDX_W-1:0] dst_reg;
  } in_item_t;

  typedef struct packed {
    logic             src1_uninit;
    logic             src2_uninit;
    logic             dead_write;
    logic [PC_W-1:0]  overwritten_pc;
    logic [CNT_W-1:0] warning_total;
  } out_item_t;

endpackage

### hw/rtl/rud_chan_if.sv
// Valid/ready channel carrying one item per handshake.
interface rud_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/rud_check.sv
// Combinational use/def check of one instruction against the register table.
module rud_check #(
  parameter int NUM_GP_REGS = rud_pkg::NUM_GP_REGS_DEF
) (
  input  rud_pkg::in_item_t               item,
  input  rud_pkg::reg_status_t            status_i [NUM_GP_REGS],
  input  logic [rud_pkg::PC_W-1:0]        last_pos_i [NUM_GP_REGS],
  input  logic [rud_pkg::CNT_W-1:0]       cnt_i,
  output rud_pkg::reg_status_t            status_nxt [NUM_GP_REGS],
  output logic                            dst_hit,
  output rud_pkg::out_item_t              result
);

  localparam int IW = rud_pkg::REG_IDX_W + 1;

  rud_pkg::reg_status_t          base [NUM_GP_REGS];
  rud_pkg::reg_status_t          st1, st2, std;
  logic [rud_pkg::PC_W-1:0]      dst_pos;
  logic                          hit1, hit2;
  logic                          uninit1, uninit2, dead;
  logic [rud_pkg::CNT_W-1:0]     cnt_base;
  logic [1:0]                    inc;
  logic [rud_pkg::CNT_W:0]       sum;

  // start clears, then label marks everything read
  always_comb begin
    for (int i = 0; i < NUM_GP_REGS; i++) begin
      if (item.is_label) begin
        base[i] = rud_pkg::ST_READ;
      end else if (item.program_start) begin
        base[i] = rud_pkg::ST_UNKNOWN;
      end else begin
        base[i] = status_i[i];
      end
    end
  end

  assign hit1    = item.src1_used && ({1'b0, item.src1_reg} < IW'(NUM_GP_REGS));
  assign hit2    = item.src2_used && ({1'b0, item.src2_reg} < IW'(NUM_GP_REGS));
  assign dst_hit = item.dst_used  && ({1'b0, item.dst_reg}  < IW'(NUM_GP_REGS));

  // table lookups by equality, so out-of-range indices select nothing
  always_comb begin
    st1     = rud_pkg::ST_UNKNOWN;
    st2     = rud_pkg::ST_UNKNOWN;
    std     = rud_pkg::ST_UNKNOWN;
    dst_pos = '0;
    for (int i = 0; i < NUM_GP_REGS; i++) begin
      if ({1'b0, item.src1_reg} == IW'(i)) st1 = base[i];
      if ({1'b0, item.src2_reg} == IW'(i)) st2 = base[i];
      if ({1'b0, item.dst_reg} == IW'(i)) begin
        std     = base[i];
        dst_pos = last_pos_i[i];
      end
    end
  end

  // a source read earlier in the same item leaves the register read
  assign uninit1 = hit1 && (st1 == rud_pkg::ST_UNKNOWN);
  assign uninit2 = hit2 && !(hit1 && item.src2_reg == item.src1_reg) &&
                   (st2 == rud_pkg::ST_UNKNOWN);
  assign dead    = dst_hit && (std == rud_pkg::ST_WRITTEN) &&
                   !(hit1 && item.dst_reg == item.src1_reg) &&
                   !(hit2 && item.dst_reg == item.src2_reg);

  always_comb begin
    for (int i = 0; i < NUM_GP_REGS; i++) begin
      status_nxt[i] = base[i];
      if (hit1 && {1'b0, item.src1_reg} == IW'(i)) status_nxt[i] = rud_pkg::ST_READ;
      if (hit2 && {1'b0, item.src2_reg} == IW'(i)) status_nxt[i] = rud_pkg::ST_READ;
      if (dst_hit && {1'b0, item.dst_reg} == IW'(i)) status_nxt[i] = rud_pkg::ST_WRITTEN;
    end
  end

  // saturating warning total
  assign cnt_base = item.program_start ? '0 : cnt_i;
  assign inc      = 2'(uninit1) + 2'(uninit2) + 2'(dead);
  assign sum      = {1'b0, cnt_base} + (rud_pkg::CNT_W + 1)'(inc);

  always_comb begin
    result.src1_uninit    = uninit1;
    result.src2_uninit    = uninit2;
    result.dead_write     = dead;
    result.overwritten_pc = dead ? dst_pos : '0;
    result.warning_total  = sum[rud_pkg::CNT_W] ? '1 : sum[rud_pkg::CNT_W-1:0];
  end

endmodule

### hw/rtl/register_use_def_checker.sv
// Top level of the register use/def checker: state table and result register.
// An accepted item's result is registered and valid in the next cycle.
// Throughput: one item per cycle unless stalled; the register status table is
// read and updated in the same cycle; the result register decouples the output.
// in_ch.ready stays high while the result register is empty or being taken.
// Reset (rst_n low, synchronous): all registers unknown, total zero, no
// result pending; write positions are left as they are.
`include "register_use_def_checker_macros.svh"

module register_use_def_checker #(
  parameter int NUM_GP_REGS = rud_pkg::NUM_GP_REGS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rud_chan_if.sink   in_ch,
  rud_chan_if.source out_ch
);

  // per-register state, kept in flops: reset and label touch every entry
  rud_pkg::reg_status_t          status_r   [NUM_GP_REGS];
  rud_pkg::reg_status_t          status_nxt [NUM_GP_REGS];
  logic [rud_pkg::PC_W-1:0]      last_pos_r [NUM_GP_REGS];
  logic [rud_pkg::CNT_W-1:0]     cnt_r;

  // result register
  logic                          out_valid_r;
  rud_pkg::out_item_t            out_item_r;
  rud_pkg::out_item_t            result;
  logic                          dst_hit;
  logic                          accept;

  // take a new item whenever the result slot is free or draining this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  rud_check #(
    .NUM_GP_REGS (NUM_GP_REGS)
  ) u_check (
    .item       (in_ch.item),
    .status_i   (status_r),
    .last_pos_i (last_pos_r),
    .cnt_i      (cnt_r),
    .status_nxt (status_nxt),
    .dst_hit    (dst_hit),
    .result     (result)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_GP_REGS; i++) status_r[i] <= rud_pkg::ST_UNKNOWN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        status_r    <= status_nxt;
        cnt_r       <= result.warning_total;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: result and write positions, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= result;
      for (int i = 0; i < NUM_GP_REGS; i++) begin
        if (dst_hit && {1'b0, in_ch.item.dst_reg} == (rud_pkg::REG_IDX_W + 1)'(i)) begin
          last_pos_r[i] <= in_ch.item.pc;
        end
      end
    end
  end

  // every accepted item yields a result next cycle
  `RUD_ASSERT_NXT(a_accept_gives_result, clk, rst_n, accept, out_valid_r)
  // a fresh program can raise at most three warnings on its first item
  `RUD_ASSERT_NXT(a_start_total_small, clk, rst_n, accept && in_ch.item.program_start,
                  out_item_r.warning_total <= 16'd3)
  // no destination, no dead write report
  `RUD_ASSERT_NXT(a_no_dst_no_dead, clk, rst_n, accept && !in_ch.item.dst_used,
                  !out_item_r.dead_write && out_item_r.overwritten_pc == '0)
  // a label makes every source look initialised
  `RUD_ASSERT_NXT(a_label_no_uninit, clk, rst_n, accept && in_ch.item.is_label,
                  !out_item_r.src1_uninit && !out_item_r.src2_uninit)
  // the running total tracks the reported total
  `RUD_ASSERT_IMP(a_total_matches, clk, rst_n, out_valid_r,
                  out_item_r.warning_total == cnt_r)

endmodule
